// File: hw/rtl/led_fade_pattern_generator_defines.svh
// ---------------------------------------------------------------------------
// led fade pattern generator assertion macros
// shared property shorthands for the port checker
// ---------------------------------------------------------------------------
`ifndef LED_FADE_PATTERN_GENERATOR_DEFINES_SVH
`define LED_FADE_PATTERN_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define LFPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lfpg check failed");

// next-cycle implication, sampled on aclk, off during reset
`define LFPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lfpg check failed");

`endif

// File: hw/rtl/lfpg_pkg.sv
// ---------------------------------------------------------------------------
// lfpg_pkg
// types and constants of the led fade pattern generator
// ---------------------------------------------------------------------------
package lfpg_pkg;

    localparam int DUTY_W = 8;
    localparam int CFG_W  = 8;
    localparam int IDX_W  = 2;

    localparam logic [DUTY_W-1:0] DUTY_ZERO      = 8'h00;
    localparam logic [DUTY_W-1:0] DUTY_HALF      = 8'h80;
    localparam logic [DUTY_W-1:0] DUTY_FULL      = 8'hFF;
    localparam logic [DUTY_W-1:0] SAVE_START_POS = 8'h08;
    localparam logic [CFG_W-1:0]  FADE_PERIOD_RESET = 8'd64;
    localparam logic [CFG_W-1:0]  ADVANCE_FLAG   = 8'd1;
    localparam logic [CFG_W-1:0]  MODE_COUNT     = 8'd4;

    typedef enum logic [IDX_W-1:0] {
        REG_FADE_PERIOD = 2'd0,
        REG_SAVED_MODE  = 2'd1,
        REG_SAVED_FLAG  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PAT_STATIC = 2'd0,
        PAT_SPLIT  = 2'd1,
        PAT_RAMP   = 2'd2,
        PAT_PULSE  = 2'd3
    } pattern_t;

endpackage

// File: hw/rtl/led_fade_pattern_generator.sv
// ---------------------------------------------------------------------------
// led fade pattern generator
// one tick per pwm period in, latched duty pair and store-write requests out
// ---------------------------------------------------------------------------
// result: registered, and valid in the cycle after the tick transfer
// throughput: one tick per cycle while the result side is ready, the next-state logic is a single
//   combinational pass between the state registers and the result register
// reset: synchronous active-low aresetn restores config, fade state and
//   latched duty values, and empties the result register
module led_fade_pattern_generator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lfpg_pkg::IDX_W-1:0]      cfg_index,
    input  logic [lfpg_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_tick,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lfpg_pkg::DUTY_W-1:0]     m_duty_a,
    output logic [lfpg_pkg::DUTY_W-1:0]     m_duty_b,
    output logic                            m_save_flag_write,
    output logic                            m_save_flag_value,
    output logic                            m_save_mode_write,
    output logic [lfpg_pkg::CFG_W-1:0]      m_save_mode_value
);

    logic [lfpg_pkg::CFG_W-1:0]  fade_period_reg;
    logic [lfpg_pkg::CFG_W-1:0]  saved_mode_reg;
    logic [lfpg_pkg::CFG_W-1:0]  saved_flag_reg;

    logic [lfpg_pkg::CFG_W-1:0]  countdown_reg,  countdown_next;
    logic [lfpg_pkg::DUTY_W-1:0] position_reg,   position_next;
    logic                        rising_reg,     rising_next;
    logic [lfpg_pkg::DUTY_W-1:0] pending_a_reg,  pending_a_next;
    logic [lfpg_pkg::DUTY_W-1:0] pending_b_reg,  pending_b_next;
    logic [lfpg_pkg::DUTY_W-1:0] latched_a_reg,  latched_a_next;
    logic [lfpg_pkg::DUTY_W-1:0] latched_b_reg,  latched_b_next;
    logic                        locked_reg,     locked_next;
    logic                        frozen_reg,     frozen_next;

    logic                        m_valid_reg;
    logic [lfpg_pkg::DUTY_W-1:0] duty_a_reg;
    logic [lfpg_pkg::DUTY_W-1:0] duty_b_reg;
    logic                        flag_write_reg, flag_write_next;
    logic                        flag_value_reg, flag_value_next;
    logic                        mode_write_reg, mode_write_next;
    logic [lfpg_pkg::CFG_W-1:0]  mode_value_reg, mode_value_next;

    logic                        s_xfer;
    logic [lfpg_pkg::CFG_W-1:0]  mode_inc;
    logic [lfpg_pkg::CFG_W-1:0]  active_mode;
    lfpg_pkg::pattern_t          pattern;
    logic [lfpg_pkg::CFG_W-1:0]  count_loaded;
    logic [lfpg_pkg::DUTY_W-1:0] pos_half;
    logic [lfpg_pkg::DUTY_W-1:0] pos_double;
    logic                        pos_low;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    // active mode from the stored mode and advance flag
    always_comb begin
        mode_inc = saved_mode_reg + 8'd1;
        if (saved_flag_reg == lfpg_pkg::ADVANCE_FLAG) begin
            active_mode = (mode_inc >= lfpg_pkg::MODE_COUNT) ? 8'd0 : mode_inc;
        end else begin
            active_mode = saved_mode_reg;
        end
        if (active_mode >= lfpg_pkg::MODE_COUNT) begin
            pattern = lfpg_pkg::PAT_PULSE;
        end else begin
            pattern = lfpg_pkg::pattern_t'(active_mode[1:0]);
        end
    end

    assign pos_half   = {1'b0, position_reg[7:1]};
    assign pos_double = {position_reg[6:0], 1'b0};
    assign pos_low    = position_reg < lfpg_pkg::DUTY_HALF;

    always_comb begin
        countdown_next  = countdown_reg;
        position_next   = position_reg;
        rising_next     = rising_reg;
        pending_a_next  = pending_a_reg;
        pending_b_next  = pending_b_reg;
        latched_a_next  = latched_a_reg;
        latched_b_next  = latched_b_reg;
        locked_next     = locked_reg;
        frozen_next     = frozen_reg;
        flag_write_next = 1'b0;
        flag_value_next = 1'b0;
        mode_write_next = 1'b0;
        mode_value_next = '0;
        count_loaded    = countdown_reg;

        if (s_tick && !frozen_reg) begin
            // fade boundary: show pending values and reload
            if (countdown_reg == 8'd0) begin
                latched_a_next = pending_a_reg;
                latched_b_next = pending_b_reg;
                count_loaded   = fade_period_reg;
            end
            countdown_next = count_loaded - 8'd1;

            if (countdown_next == 8'd1 && !locked_reg) begin
                if (position_reg == lfpg_pkg::SAVE_START_POS) begin
                    flag_write_next = 1'b1;
                    flag_value_next = 1'b1;
                    mode_write_next = 1'b1;
                    mode_value_next = active_mode;
                end else if (position_reg == lfpg_pkg::DUTY_FULL) begin
                    flag_write_next = 1'b1;
                    locked_next     = 1'b1;
                    frozen_next     = (active_mode == 8'd0);
                end
            end else if (countdown_next == 8'd0) begin
                case (pattern)
                    lfpg_pkg::PAT_STATIC: begin
                        pending_a_next = lfpg_pkg::DUTY_HALF;
                        pending_b_next = lfpg_pkg::DUTY_HALF;
                    end
                    lfpg_pkg::PAT_SPLIT: begin
                        pending_a_next = pos_half;
                        pending_b_next = lfpg_pkg::DUTY_FULL - pos_half;
                    end
                    lfpg_pkg::PAT_RAMP: begin
                        pending_a_next = position_reg;
                        pending_b_next = position_reg;
                    end
                    default: begin
                        if (rising_reg) begin
                            pending_a_next = pos_low ? pos_double
                                                     : lfpg_pkg::DUTY_FULL - pos_double;
                            pending_b_next = lfpg_pkg::DUTY_FULL;
                        end else begin
                            pending_a_next = lfpg_pkg::DUTY_ZERO;
                            pending_b_next = pos_low ? lfpg_pkg::DUTY_FULL - pos_double
                                                     : pos_double;
                        end
                    end
                endcase
                position_next = rising_reg ? position_reg + 8'd1 : position_reg - 8'd1;
                rising_next   = (rising_reg || position_next == lfpg_pkg::DUTY_ZERO)
                                && position_next != lfpg_pkg::DUTY_FULL;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_period_reg <= lfpg_pkg::FADE_PERIOD_RESET;
            saved_mode_reg  <= '0;
            saved_flag_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lfpg_pkg::REG_FADE_PERIOD: fade_period_reg <= cfg_wdata;
                lfpg_pkg::REG_SAVED_MODE:  saved_mode_reg  <= cfg_wdata;
                lfpg_pkg::REG_SAVED_FLAG:  saved_flag_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // fade state, updated on each tick transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg <= lfpg_pkg::FADE_PERIOD_RESET;
            position_reg  <= lfpg_pkg::DUTY_ZERO;
            rising_reg    <= 1'b1;
            pending_a_reg <= lfpg_pkg::DUTY_ZERO;
            pending_b_reg <= lfpg_pkg::DUTY_FULL;
            latched_a_reg <= lfpg_pkg::DUTY_ZERO;
            latched_b_reg <= lfpg_pkg::DUTY_FULL;
            locked_reg    <= 1'b0;
            frozen_reg    <= 1'b0;
        end else if (s_xfer) begin
            countdown_reg <= countdown_next;
            position_reg  <= position_next;
            rising_reg    <= rising_next;
            pending_a_reg <= pending_a_next;
            pending_b_reg <= pending_b_next;
            latched_a_reg <= latched_a_next;
            latched_b_reg <= latched_b_next;
            locked_reg    <= locked_next;
            frozen_reg    <= frozen_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            duty_a_reg     <= latched_a_next;
            duty_b_reg     <= latched_b_next;
            flag_write_reg <= flag_write_next;
            flag_value_reg <= flag_value_next;
            mode_write_reg <= mode_write_next;
            mode_value_reg <= mode_value_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_duty_a          = duty_a_reg;
    assign m_duty_b          = duty_b_reg;
    assign m_save_flag_write = flag_write_reg;
    assign m_save_flag_value = flag_value_reg;
    assign m_save_mode_write = mode_write_reg;
    assign m_save_mode_value = mode_value_reg;

endmodule

// File: hw/rtl/lfpg_checker.sv
// ---------------------------------------------------------------------------
// lfpg_checker
// port-level checks of the led fade pattern generator, bound to the top level
// ---------------------------------------------------------------------------
`include "led_fade_pattern_generator_defines.svh"

module lfpg_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [lfpg_pkg::DUTY_W-1:0]     m_duty_a,
    input logic [lfpg_pkg::DUTY_W-1:0]     m_duty_b,
    input logic                            m_save_flag_write,
    input logic                            m_save_flag_value,
    input logic                            m_save_mode_write,
    input logic [lfpg_pkg::CFG_W-1:0]      m_save_mode_value
);

    // stalled result holds
    `LFPG_ASSERT_NEXT(a_result_hold, m_valid && !m_ready,
        m_valid && $stable(m_duty_a) && $stable(m_duty_b))

    // every tick transfer yields a result
    `LFPG_ASSERT_NEXT(a_tick_gives_result, s_valid && s_ready, m_valid)

    // mode save only comes with a flag-one save
    `LFPG_ASSERT_NOW(a_mode_with_flag, m_valid && m_save_mode_write,
        m_save_flag_write && m_save_flag_value)

    // no request means zero values
    `LFPG_ASSERT_NOW(a_idle_values_zero, m_valid && !m_save_flag_write,
        !m_save_flag_value && !m_save_mode_write && m_save_mode_value == 8'd0)

endmodule

bind led_fade_pattern_generator lfpg_checker u_lfpg_checker (.*);

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// led fade pattern generator testbench
// drives ticks through the valid/ready input under random gaps and stalls,
// predicts each latched duty pair and store-write request in a scoreboard
// class, and walks the fade position through the save window, the mode lock
// at the top of the first sweep and part of the fall, changing registers
// between phases
// ---------------------------------------------------------------------------
module testbench;

    localparam int ITEM_COUNT  = 650;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [lfpg_pkg::DUTY_W-1:0] duty_a;
        logic [lfpg_pkg::DUTY_W-1:0] duty_b;
        logic                        flag_write;
        logic                        flag_value;
        logic                        mode_write;
        logic [lfpg_pkg::CFG_W-1:0]  mode_value;
    } duty_result_t;

    class duty_tracker;
        logic [lfpg_pkg::CFG_W-1:0]  period_reg;
        logic [lfpg_pkg::CFG_W-1:0]  mode_reg;
        logic [lfpg_pkg::CFG_W-1:0]  flag_reg;
        logic [lfpg_pkg::CFG_W-1:0]  countdown;
        logic [lfpg_pkg::DUTY_W-1:0] position;
        logic [lfpg_pkg::DUTY_W-1:0] next_a;
        logic [lfpg_pkg::DUTY_W-1:0] next_b;
        logic [lfpg_pkg::DUTY_W-1:0] shown_a;
        logic [lfpg_pkg::DUTY_W-1:0] shown_b;
        bit                          rising;
        bit                          locked;
        bit                          frozen;
        duty_result_t                awaited_duty[$];
        int                          errors;

        function new();
            period_reg = lfpg_pkg::FADE_PERIOD_RESET;
            mode_reg   = '0;
            flag_reg   = '0;
            countdown  = lfpg_pkg::FADE_PERIOD_RESET;
            position   = lfpg_pkg::DUTY_ZERO;
            rising     = 1'b1;
            next_a     = lfpg_pkg::DUTY_ZERO;
            next_b     = lfpg_pkg::DUTY_FULL;
            shown_a    = lfpg_pkg::DUTY_ZERO;
            shown_b    = lfpg_pkg::DUTY_FULL;
            locked     = 1'b0;
            frozen     = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(lfpg_pkg::cfg_reg_t idx, logic [lfpg_pkg::CFG_W-1:0] value);
            case (idx)
                lfpg_pkg::REG_FADE_PERIOD: period_reg = value;
                lfpg_pkg::REG_SAVED_MODE:  mode_reg = value;
                lfpg_pkg::REG_SAVED_FLAG:  flag_reg = value;
                default: ;
            endcase
        endfunction

        function logic [lfpg_pkg::CFG_W-1:0] live_mode();
            logic [lfpg_pkg::CFG_W-1:0] m;
            m = mode_reg;
            if (flag_reg == lfpg_pkg::ADVANCE_FLAG) begin
                m = m + 8'd1;
                if (m >= lfpg_pkg::MODE_COUNT) m = '0;
            end
            return m;
        endfunction

        function lfpg_pkg::pattern_t pattern_of(logic [lfpg_pkg::CFG_W-1:0] m);
            if (m >= lfpg_pkg::MODE_COUNT) return lfpg_pkg::PAT_PULSE;
            return lfpg_pkg::pattern_t'(m[1:0]);
        endfunction

        function void load_pattern(logic [lfpg_pkg::CFG_W-1:0] m);
            logic [lfpg_pkg::DUTY_W-1:0] dbl;
            dbl = position << 1;
            case (pattern_of(m))
                lfpg_pkg::PAT_STATIC: begin
                    next_a = lfpg_pkg::DUTY_HALF;
                    next_b = lfpg_pkg::DUTY_HALF;
                end
                lfpg_pkg::PAT_SPLIT: begin
                    next_a = position >> 1;
                    next_b = lfpg_pkg::DUTY_FULL - (position >> 1);
                end
                lfpg_pkg::PAT_RAMP: begin
                    next_a = position;
                    next_b = position;
                end
                lfpg_pkg::PAT_PULSE: begin
                    if (rising) begin
                        next_a = (position < lfpg_pkg::DUTY_HALF) ? dbl
                                                                  : lfpg_pkg::DUTY_FULL - dbl;
                        next_b = lfpg_pkg::DUTY_FULL;
                    end else begin
                        next_a = lfpg_pkg::DUTY_ZERO;
                        next_b = (position < lfpg_pkg::DUTY_HALF) ? lfpg_pkg::DUTY_FULL - dbl
                                                                  : dbl;
                    end
                end
                default: ;
            endcase
        endfunction

        function void accept_tick(logic t);
            duty_result_t               r;
            logic [lfpg_pkg::CFG_W-1:0] m;
            m            = live_mode();
            r.flag_write = 1'b0;
            r.flag_value = 1'b0;
            r.mode_write = 1'b0;
            r.mode_value = '0;
            if (t && !frozen) begin
                if (countdown == '0) begin
                    shown_a   = next_a;
                    shown_b   = next_b;
                    countdown = period_reg;
                end
                countdown = countdown - 8'd1;
                if (countdown == 8'd1 && !locked) begin
                    if (position == lfpg_pkg::SAVE_START_POS) begin
                        r.flag_write = 1'b1;
                        r.flag_value = 1'b1;
                        r.mode_write = 1'b1;
                        r.mode_value = m;
                    end else if (position == lfpg_pkg::DUTY_FULL) begin
                        r.flag_write = 1'b1;
                        locked       = 1'b1;
                        frozen       = (pattern_of(m) == lfpg_pkg::PAT_STATIC);
                    end
                end else if (countdown == '0) begin
                    load_pattern(m);
                    position = rising ? position + 8'd1 : position - 8'd1;
                    rising   = (rising || position == lfpg_pkg::DUTY_ZERO)
                               && position != lfpg_pkg::DUTY_FULL;
                end
            end
            r.duty_a = shown_a;
            r.duty_b = shown_b;
            awaited_duty.push_back(r);
        endfunction

        function void check_result(duty_result_t got);
            duty_result_t want;
            logic [7:0]   want_v [6];
            logic [7:0]   got_v [6];
            string        field_name [6];
            field_name = '{"duty_a", "duty_b", "save_flag_write", "save_flag_value",
                           "save_mode_write", "save_mode_value"};
            if (awaited_duty.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, duty_a %0d duty_b %0d",
                         $time, got.duty_a, got.duty_b);
                return;
            end
            want   = awaited_duty.pop_front();
            want_v = '{want.duty_a, want.duty_b, 8'(want.flag_write), 8'(want.flag_value),
                       8'(want.mode_write), want.mode_value};
            got_v  = '{got.duty_a, got.duty_b, 8'(got.flag_write), 8'(got.flag_value),
                       8'(got.mode_write), got.mode_value};
            for (int i = 0; i < 6; i++) begin
                if (want_v[i] !== got_v[i]) begin
                    errors++;
                    $display("%0t: %s expected %0d, actual %0d",
                             $time, field_name[i], want_v[i], got_v[i]);
                end
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [lfpg_pkg::IDX_W-1:0]    cfg_index;
    logic [lfpg_pkg::CFG_W-1:0]    cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_tick;
    logic                          m_valid;
    logic                          m_ready;
    logic [lfpg_pkg::DUTY_W-1:0]   m_duty_a;
    logic [lfpg_pkg::DUTY_W-1:0]   m_duty_b;
    logic                          m_save_flag_write;
    logic                          m_save_flag_value;
    logic                          m_save_mode_write;
    logic [lfpg_pkg::CFG_W-1:0]    m_save_mode_value;

    duty_tracker tracker;
    bit          calm;
    int          quiet_cycles;

    led_fade_pattern_generator dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_tick            (s_tick),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_duty_a          (m_duty_a),
        .m_duty_b          (m_duty_b),
        .m_save_flag_write (m_save_flag_write),
        .m_save_flag_value (m_save_flag_value),
        .m_save_mode_write (m_save_mode_write),
        .m_save_mode_value (m_save_mode_value)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_tick(input logic t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_tick  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.accept_tick(t);
    endtask

    task automatic write_cfg(input lfpg_pkg::cfg_reg_t idx,
                             input logic [lfpg_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.write_reg(idx, value);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.awaited_duty.size() > 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // result side: random stalls, long ready runs when calm
    initial begin
        int hold;
        int run;
        m_ready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            run = calm ? 32 : $urandom_range(1, 12);
            repeat (run) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_monitor
        duty_result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.duty_a     = m_duty_a;
            seen.duty_b     = m_duty_b;
            seen.flag_write = m_save_flag_write;
            seen.flag_value = m_save_flag_value;
            seen.mode_write = m_save_mode_write;
            seen.mode_value = m_save_mode_value;
            tracker.check_result(seen);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("led_fade_pattern_generator regression: fail");
            $finish;
        end
    end

    initial begin
        logic                       opening [6];
        logic [lfpg_pkg::CFG_W-1:0] period;
        logic [lfpg_pkg::CFG_W-1:0] mode;
        logic [lfpg_pkg::CFG_W-1:0] flag;
        logic                       t;
        int                         ones;
        int                         len;
        int                         pos;
        int                         phase;
        int                         r;
        int                         ticks_sent;
        bit                         climbing;
        bit                         freeze_at_top;
        bit                         did_wrap;
        bit                         long_phase;

        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= lfpg_pkg::REG_FADE_PERIOD;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_tick    <= 1'b0;
        opening       = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        tracker       = new();
        calm          = 1'b0;
        phase         = 0;
        ticks_sent    = 0;
        did_wrap      = 1'b0;
        // mode byte at the top of the first sweep decides lock-only or halt
        freeze_at_top = ($urandom_range(0, 3) == 0);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // idle and live ticks straight out of reset
        foreach (opening[i]) send_tick(opening[i]);

        while (!(ticks_sent >= ITEM_COUNT && tracker.locked &&
                 (tracker.frozen || (!tracker.rising && tracker.position < 8'd240))) &&
               ticks_sent < 4 * ITEM_COUNT) begin
            drain();
            phase++;
            calm     = ($urandom_range(0, 3) == 0);
            pos      = int'(tracker.position);
            climbing = tracker.rising && !tracker.locked;

            r    = $urandom_range(0, 99);
            mode = (r < 50) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
            r    = $urandom_range(0, 99);
            flag = (r < 45) ? lfpg_pkg::ADVANCE_FLAG
                            : (r < 70) ? 8'd0 : 8'($urandom_range(0, 255));
            if (phase == 1) begin
                mode = '1;
                flag = '1;
            end else if (phase == 2) begin
                mode = '1;
                flag = lfpg_pkg::ADVANCE_FLAG;
            end
            if (climbing && pos >= 240) begin
                r = $urandom_range(0, 2);
                if (freeze_at_top) begin
                    mode = (r == 0) ? 8'd0 : (r == 1) ? lfpg_pkg::MODE_COUNT - 8'd1 : 8'hFF;
                    flag = (r == 0) ? 8'd0 : lfpg_pkg::ADVANCE_FLAG;
                end else begin
                    mode = (r == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(1, 255));
                    flag = (r == 0) ? lfpg_pkg::ADVANCE_FLAG : 8'($urandom_range(2, 255));
                end
            end

            long_phase = 1'b0;
            if (climbing && (pos <= 9 || pos >= 240)) begin
                // save window and lock point need the countdown to pass one
                period = 8'($urandom_range(2, 3));
                len    = $urandom_range(8, 24);
            end else if (climbing && pos >= 40 && !did_wrap) begin
                period     = '0;
                did_wrap   = 1'b1;
                long_phase = 1'b1;
                len        = 0;
            end else begin
                period = ($urandom_range(0, 99) < 90) ? 8'd1 : 8'($urandom_range(2, 4));
                len    = $urandom_range(10, 50);
                if (climbing && len > 240 - pos) len = 240 - pos;
            end
            // run through the reload and one full step at the wrapped period
            if (long_phase) len = int'(tracker.countdown) + 256;

            write_cfg(lfpg_pkg::REG_FADE_PERIOD, period);
            write_cfg(lfpg_pkg::REG_SAVED_MODE, mode);
            write_cfg(lfpg_pkg::REG_SAVED_FLAG, flag);
            cfg_we <= 1'b0;

            ones = 0;
            while (ones < len) begin
                t = ($urandom_range(0, 9) != 0);
                send_tick(t);
                ones += int'(t);
                ticks_sent++;
            end
        end

        drain();
        if (tracker.errors == 0 && tracker.awaited_duty.size() == 0) begin
            $display("led_fade_pattern_generator regression: pass");
        end else begin
            $display("led_fade_pattern_generator regression: fail");
        end
        $finish;
    end
endmodule
